@@ src/char_range_set_table_macros.svh @@
// ----------------------------------------------------------------------------
// char_range_set_table_macros
// Assertion shorthands shared by the range set table checkers.
// ----------------------------------------------------------------------------
`ifndef CHAR_RANGE_SET_TABLE_MACROS_SVH
`define CHAR_RANGE_SET_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CRST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("range set table check failed");

// Next-cycle implication, disabled while reset is asserted
`define CRST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("range set table check failed");

`endif

@@ src/crst_pkg.sv @@
// ----------------------------------------------------------------------------
// crst_pkg
// Shared constants, codes, types and helpers of the range set table.
// ----------------------------------------------------------------------------
package crst_pkg;

    // Code point field
    localparam int CP_W           = 21;
    localparam logic [CP_W-1:0] CODE_POINT_MAX = 21'h10FFFF;

    // Table geometry
    localparam int MAX_RANGES_DEF = 64;
    localparam int ENTRY_W        = 2 * CP_W;

    // Result field widths
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;

    // Operation codes
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_TEST   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // Classification of one stored range against the key pair
    typedef struct packed {
        logic            gap_below;  // range ends with a gap below key_lo
        logic            gap_above;  // range starts with a gap above key_hi
        logic            has_lo;     // range holds key_lo
        logic            has_hi;     // range holds key_hi
        logic [CP_W-1:0] merge_lo;   // lower end of range merged with keys
        logic [CP_W-1:0] merge_hi;   // upper end of range merged with keys
    } crst_cls_t;

    // Saturate a code point to the top of the Unicode space
    function automatic logic [CP_W-1:0] clamp_cp(input logic [CP_W-1:0] x);
        clamp_cp = (x > CODE_POINT_MAX) ? CODE_POINT_MAX : x;
    endfunction

endpackage

@@ src/crst_ram.sv @@
// ----------------------------------------------------------------------------
// crst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module crst_ram
    import crst_pkg::*;
#(
    parameter int WIDTH = ENTRY_W,
    parameter int DEPTH = MAX_RANGES_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port, hold data when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/crst_unit.sv @@
// ----------------------------------------------------------------------------
// crst_unit
// Shared compare unit: classifies one stored range against the key pair,
// forms the merged range, and picks the pair to write and its width.
// ----------------------------------------------------------------------------
module crst_unit
    import crst_pkg::*;
(
    input  logic [CP_W-1:0] ent_start,
    input  logic [CP_W-1:0] ent_stop,
    input  logic [CP_W-1:0] key_lo,
    input  logic [CP_W-1:0] key_hi,
    input  logic            use_key,
    output crst_cls_t       cls,
    output logic [CP_W-1:0] sel_start,
    output logic [CP_W-1:0] sel_stop,
    output logic [CP_W-1:0] sel_width
);

    logic [CP_W:0] stop_inc;
    logic [CP_W:0] hi_inc;

    assign stop_inc = {1'b0, ent_stop} + {{CP_W{1'b0}}, 1'b1};
    assign hi_inc   = {1'b0, key_hi} + {{CP_W{1'b0}}, 1'b1};

    // Classify against the keys
    always_comb
    begin
        cls.gap_below = stop_inc < {1'b0, key_lo};
        cls.gap_above = {1'b0, ent_start} > hi_inc;
        cls.has_lo    = (ent_start <= key_lo) && (key_lo <= ent_stop);
        cls.has_hi    = (ent_start <= key_hi) && (key_hi <= ent_stop);
        cls.merge_lo  = (ent_start < key_lo) ? ent_start : key_lo;
        cls.merge_hi  = (ent_stop > key_hi) ? ent_stop : key_hi;
    end

    // Select pair to write and measure it
    assign sel_start = use_key ? key_lo : ent_start;
    assign sel_stop  = use_key ? key_hi : ent_stop;
    assign sel_width = sel_stop - sel_start + {{(CP_W-1){1'b0}}, 1'b1};

endmodule

@@ src/char_range_set_table.sv @@
// ----------------------------------------------------------------------------
// char_range_set_table
// Sorted table of disjoint, non-adjacent code-point ranges with add-merge,
// look-up, containment test and clear, driven by a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake         Payload
//  --------  ----------------  ------------------------------------------------
//  request   start / busy      operation, range_start, range_stop, query_char
//  result    done (1 cycle)    hit, range_index, range_count, total_length,
//                              overflow
//
//  An item is taken when start is high and busy is low; busy stays high
//  until its result. One shared compare unit visits the stored ranges one at
//  a time, each in a RAM read state and an evaluate state. Add passes a
//  pending state as well when the new range lands before a kept range;
//  look-up and test stop at a range holding both keys; clear skips the scan.
//  Add rebuilds the table into the spare RAM bank and flips banks at the end,
//  so a refused add leaves the table as it was. Reset empties the table at
//  once; no clearing pass. The receiver cannot stall: done lasts one cycle.
//
module char_range_set_table
    import crst_pkg::*;
#(
    parameter int MAX_RANGES = MAX_RANGES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         operation,
    input  logic [CP_W-1:0]    range_start,
    input  logic [CP_W-1:0]    range_stop,
    input  logic [CP_W-1:0]    query_char,
    output logic               done,
    output logic               hit,
    output logic [INDEX_W-1:0] range_index,
    output logic [COUNT_W-1:0] range_count,
    output logic [CP_W-1:0]    total_length,
    output logic               overflow
);

    localparam int IDX_W = $clog2(MAX_RANGES);
    localparam int CNT_W = $clog2(MAX_RANGES + 1);
    localparam int NW    = $clog2(MAX_RANGES + 2);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EV   = 3'd2;
    localparam logic [2:0] S_PEND = 3'd3;
    localparam logic [2:0] S_TAIL = 3'd4;

    logic [2:0]         state_reg,  state_next;
    logic [1:0]         op_reg,     op_next;
    logic [CP_W-1:0]    lo_reg,     lo_next;
    logic [CP_W-1:0]    hi_reg,     hi_next;
    logic [CNT_W-1:0]   i_reg,      i_next;
    logic [NW-1:0]      n_reg,      n_next;
    logic [CP_W-1:0]    acc_reg,    acc_next;
    logic               placed_reg, placed_next;
    logic               found_reg,  found_next;
    logic [IDX_W-1:0]   idx_reg,    idx_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic [CP_W-1:0]    total_reg,  total_next;
    logic               bank_reg,   bank_next;
    logic               done_reg,   done_next;
    logic               hit_reg,    hit_next;
    logic [INDEX_W-1:0] index_reg,  index_next;
    logic [COUNT_W-1:0] rcount_reg, rcount_next;
    logic [CP_W-1:0]    rtotal_reg, rtotal_next;
    logic               over_reg,   over_next;

    logic               rd_en;
    logic               wr_req;
    logic               wr_en;
    logic               wr_key;
    logic [ENTRY_W-1:0] rdata0;
    logic [ENTRY_W-1:0] rdata1;
    logic [ENTRY_W-1:0] rdata;
    logic [ENTRY_W-1:0] wdata;
    crst_cls_t          cls;
    logic [CP_W-1:0]    sel_start;
    logic [CP_W-1:0]    sel_stop;
    logic [CP_W-1:0]    sel_width;
    logic [CP_W-1:0]    acc_add;
    logic [CNT_W-1:0]   i_inc;
    logic               last_ev;
    logic               last_pend;
    logic [NW-1:0]      n_fin;
    logic [CP_W-1:0]    total_fin;
    logic [CP_W-1:0]    cl_start;
    logic [CP_W-1:0]    cl_stop;
    logic [IDX_W+INDEX_W-1:0] idx_wide;
    logic [CNT_W+COUNT_W-1:0] cnt_wide;

    // Table banks: read the active one, rebuild into the other
    crst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_RANGES)
    ) u_bank0 (
        .clk   (clk),
        .we    (wr_en & bank_reg),
        .waddr (n_reg[IDX_W-1:0]),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (i_reg[IDX_W-1:0]),
        .rdata (rdata0)
    );

    crst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_RANGES)
    ) u_bank1 (
        .clk   (clk),
        .we    (wr_en & ~bank_reg),
        .waddr (n_reg[IDX_W-1:0]),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (i_reg[IDX_W-1:0]),
        .rdata (rdata1)
    );

    assign rdata = bank_reg ? rdata1 : rdata0;

    // Shared compare unit
    crst_unit u_unit (
        .ent_start (rdata[ENTRY_W-1:CP_W]),
        .ent_stop  (rdata[CP_W-1:0]),
        .key_lo    (lo_reg),
        .key_hi    (hi_reg),
        .use_key   (wr_key),
        .cls       (cls),
        .sel_start (sel_start),
        .sel_stop  (sel_stop),
        .sel_width (sel_width)
    );

    assign wdata     = {sel_start, sel_stop};
    assign wr_en     = wr_req && (n_reg < NW'(MAX_RANGES));
    assign acc_add   = acc_reg + sel_width;
    assign i_inc     = i_reg + CNT_W'(1);
    assign last_ev   = (i_inc == count_reg);
    assign last_pend = (i_reg == count_reg);
    assign n_fin     = placed_reg ? n_reg : (n_reg + NW'(1));
    assign total_fin = placed_reg ? acc_reg : acc_add;
    assign cl_start  = clamp_cp(range_start);
    assign cl_stop   = clamp_cp(range_stop);

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        i_next      = i_reg;
        n_next      = n_reg;
        acc_next    = acc_reg;
        placed_next = placed_reg;
        found_next  = found_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        total_next  = total_reg;
        bank_next   = bank_reg;
        done_next   = 1'b0;
        hit_next    = hit_reg;
        index_next  = index_reg;
        rcount_next = rcount_reg;
        rtotal_next = rtotal_reg;
        over_next   = over_reg;
        rd_en       = 1'b0;
        wr_req      = 1'b0;
        wr_key      = 1'b0;
        idx_wide    = {{INDEX_W{1'b0}}, idx_reg};
        cnt_wide    = {{COUNT_W{1'b0}}, count_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                // Take an item, set up keys
                if (start)
                begin
                    op_next     = operation;
                    i_next      = '0;
                    n_next      = '0;
                    acc_next    = '0;
                    placed_next = 1'b0;
                    found_next  = 1'b0;
                    idx_next    = '0;
                    unique case (operation)
                        OP_ADD:
                        begin
                            lo_next = (cl_start > cl_stop) ? cl_stop : cl_start;
                            hi_next = (cl_start > cl_stop) ? cl_start : cl_stop;
                        end
                        OP_LOOKUP:
                        begin
                            lo_next = query_char;
                            hi_next = query_char;
                        end
                        default:
                        begin
                            lo_next = range_start;
                            hi_next = range_stop;
                        end
                    endcase
                    if (operation == OP_CLEAR || count_reg == '0)
                    begin
                        state_next = S_TAIL;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end

            S_RD:
            begin
                // Fetch stored range i
                rd_en      = 1'b1;
                state_next = S_EV;
            end

            S_EV:
            begin
                i_next = i_inc;
                if (op_reg == OP_ADD)
                begin
                    priority if (cls.gap_below)
                    begin
                        // Keep range below the new one
                        wr_req     = 1'b1;
                        n_next     = n_reg + NW'(1);
                        acc_next   = acc_add;
                        state_next = last_ev ? S_TAIL : S_RD;
                    end
                    else if (cls.gap_above && !placed_reg)
                    begin
                        // Place new range, keep this one next cycle
                        wr_req      = 1'b1;
                        wr_key      = 1'b1;
                        n_next      = n_reg + NW'(1);
                        acc_next    = acc_add;
                        placed_next = 1'b1;
                        state_next  = S_PEND;
                    end
                    else if (cls.gap_above)
                    begin
                        // Keep range above the placed one
                        wr_req     = 1'b1;
                        n_next     = n_reg + NW'(1);
                        acc_next   = acc_add;
                        state_next = last_ev ? S_TAIL : S_RD;
                    end
                    else
                    begin
                        // Absorb overlapping or adjoining range
                        lo_next    = cls.merge_lo;
                        hi_next    = cls.merge_hi;
                        state_next = last_ev ? S_TAIL : S_RD;
                    end
                end
                else
                begin
                    // Search for a range holding both keys
                    if (cls.has_lo && cls.has_hi)
                    begin
                        found_next = 1'b1;
                        idx_next   = i_reg[IDX_W-1:0];
                        state_next = S_TAIL;
                    end
                    else
                    begin
                        state_next = last_ev ? S_TAIL : S_RD;
                    end
                end
            end

            S_PEND:
            begin
                // Write the held range after the placed one
                wr_req     = 1'b1;
                n_next     = n_reg + NW'(1);
                acc_next   = acc_add;
                state_next = last_pend ? S_TAIL : S_RD;
            end

            S_TAIL:
            begin
                // Finish: commit or refuse, drive result
                hit_next   = found_reg;
                index_next = idx_wide[INDEX_W-1:0];
                over_next  = 1'b0;
                unique case (op_reg)
                    OP_ADD:
                    begin
                        wr_req = !placed_reg;
                        wr_key = 1'b1;
                        if (n_fin > NW'(MAX_RANGES))
                        begin
                            over_next = 1'b1;
                        end
                        else
                        begin
                            count_next = n_fin[CNT_W-1:0];
                            total_next = total_fin;
                            bank_next  = ~bank_reg;
                        end
                    end
                    OP_CLEAR:
                    begin
                        count_next = '0;
                        total_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
                cnt_wide    = {{COUNT_W{1'b0}}, count_next};
                rcount_next = cnt_wide[COUNT_W-1:0];
                rtotal_next = total_next;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_reg     <= OP_ADD;
            lo_reg     <= '0;
            hi_reg     <= '0;
            i_reg      <= '0;
            n_reg      <= '0;
            acc_reg    <= '0;
            placed_reg <= 1'b0;
            found_reg  <= 1'b0;
            idx_reg    <= '0;
            count_reg  <= '0;
            total_reg  <= '0;
            bank_reg   <= 1'b0;
            done_reg   <= 1'b0;
            hit_reg    <= 1'b0;
            index_reg  <= '0;
            rcount_reg <= '0;
            rtotal_reg <= '0;
            over_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            i_reg      <= i_next;
            n_reg      <= n_next;
            acc_reg    <= acc_next;
            placed_reg <= placed_next;
            found_reg  <= found_next;
            idx_reg    <= idx_next;
            count_reg  <= count_next;
            total_reg  <= total_next;
            bank_reg   <= bank_next;
            done_reg   <= done_next;
            hit_reg    <= hit_next;
            index_reg  <= index_next;
            rcount_reg <= rcount_next;
            rtotal_reg <= rtotal_next;
            over_reg   <= over_next;
        end
    end

    // Drive ports
    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign hit          = hit_reg;
    assign range_index  = index_reg;
    assign range_count  = rcount_reg;
    assign total_length = rtotal_reg;
    assign overflow     = over_reg;

endmodule

@@ src/crst_checker.sv @@
// ----------------------------------------------------------------------------
// crst_checker
// Port-level checks of the range set table, bound to the top level.
// ----------------------------------------------------------------------------
`include "char_range_set_table_macros.svh"

module crst_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic       hit,
    input logic [5:0] range_index,
    input logic       overflow
);

    // Result only once the block is free again
    `CRST_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy)

    // Taken item keeps the block busy
    `CRST_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)

    // Busy drops only with a result
    `CRST_ASSERT_IMP(a_fell_done, clk, rst_n, $fell(busy), done)

    // Refused add never reports a hit
    `CRST_ASSERT_IMP(a_over_nohit, clk, rst_n, done && overflow, !hit)

    // Miss reports index zero
    `CRST_ASSERT_IMP(a_miss_index, clk, rst_n, done && !hit, range_index == 6'd0)

endmodule

bind char_range_set_table crst_checker u_crst_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .hit         (hit),
    .range_index (range_index),
    .overflow    (overflow)
);
